// ===== hdl/tsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the touch swipe detector.
// No dependencies.
package tsd_pkg;

    localparam int PANEL_SIZE   = 480;
    localparam int COORD_W      = 9;
    localparam int SWIPE_W      = 2;

    localparam logic [COORD_W-1:0] THRESH_RESET = COORD_W'(60);

    localparam logic [SWIPE_W-1:0] SWIPE_NONE  = 2'd0;
    localparam logic [SWIPE_W-1:0] SWIPE_LEFT  = 2'd1;
    localparam logic [SWIPE_W-1:0] SWIPE_RIGHT = 2'd2;

    typedef struct packed {
        logic               touched;
        logic               dimmed;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
    } t_tsd_in;

    typedef struct packed {
        logic               pressed;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               touch_start;
        logic               activity;
        logic [SWIPE_W-1:0] swipe;
    } t_tsd_out;

endpackage

// ===== hdl/tsd_step.sv =====
`timescale 1ns / 1ps
// Touch tracking state and the per-transaction gesture logic.
// Depends on tsd_pkg.
module tsd_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  tsd_pkg::t_tsd_in              i_item,
    input  logic [tsd_pkg::COORD_W-1:0]   i_threshold,
    output tsd_pkg::t_tsd_out             o_result
);
    import tsd_pkg::*;

    localparam int            ROT_W = $clog2(PANEL_SIZE) + 2;
    localparam logic [ROT_W-1:0] TOP     = ROT_W'(PANEL_SIZE - 1);
    localparam logic [ROT_W-1:0] SAT_MAX = ROT_W'((1 << COORD_W) - 1);

    logic               r_touch_active, n_touch_active;
    logic               r_swallow,      n_swallow;
    logic [COORD_W-1:0] r_start_x, n_start_x;
    logic [COORD_W-1:0] r_start_y, n_start_y;
    logic [COORD_W-1:0] r_last_x,  n_last_x;
    logic [COORD_W-1:0] r_last_y,  n_last_y;

    logic [ROT_W-1:0]   w_rx_ext;
    logic [ROT_W-1:0]   w_rot_diff;
    logic [COORD_W-1:0] w_rot_y;
    logic [COORD_W-1:0] w_adx;
    logic [COORD_W-1:0] w_ady;

    // 270 degree rotation: y = top - raw_x, clamped to [0, 479]
    always_comb begin
        w_rx_ext   = ROT_W'(i_item.raw_x);
        w_rot_diff = TOP - w_rx_ext;
        if (w_rx_ext > TOP) begin
            w_rot_y = '0;
        end else if (w_rot_diff > SAT_MAX) begin
            w_rot_y = '1;
        end else begin
            w_rot_y = w_rot_diff[COORD_W-1:0];
        end
    end

    assign w_adx = (r_last_x >= r_start_x) ? r_last_x - r_start_x : r_start_x - r_last_x;
    assign w_ady = (r_last_y >= r_start_y) ? r_last_y - r_start_y : r_start_y - r_last_y;

    always_comb begin
        n_touch_active = r_touch_active;
        n_swallow      = r_swallow;
        n_start_x      = r_start_x;
        n_start_y      = r_start_y;
        n_last_x       = r_last_x;
        n_last_y       = r_last_y;
        o_result       = '0;

        if (i_item.touched) begin
            o_result.activity = 1'b1;
            n_swallow = r_swallow | i_item.dimmed;
            if (n_swallow) begin
                // press in progress is dropped, no swipe check
                n_touch_active = 1'b0;
            end else begin
                o_result.pressed = 1'b1;
                o_result.point_x = i_item.raw_y;
                o_result.point_y = w_rot_y;
                if (!r_touch_active) begin
                    n_touch_active       = 1'b1;
                    n_start_x            = i_item.raw_y;
                    n_start_y            = w_rot_y;
                    o_result.touch_start = 1'b1;
                end
                n_last_x = i_item.raw_y;
                n_last_y = w_rot_y;
            end
        end else begin
            n_swallow = 1'b0;
            if (r_touch_active) begin
                n_touch_active = 1'b0;
                if (w_adx > i_threshold && w_adx > w_ady) begin
                    o_result.swipe = (r_last_x < r_start_x) ? SWIPE_LEFT : SWIPE_RIGHT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_active <= 1'b0;
            r_swallow      <= 1'b0;
            r_start_x      <= '0;
            r_start_y      <= '0;
            r_last_x       <= '0;
            r_last_y       <= '0;
        end else if (i_fire) begin
            r_touch_active <= n_touch_active;
            r_swallow      <= n_swallow;
            r_start_x      <= n_start_x;
            r_start_y      <= n_start_y;
            r_last_x       <= n_last_x;
            r_last_y       <= n_last_y;
        end
    end

endmodule

// ===== hdl/touch_swipe_detector_unit.sv =====
`timescale 1ns / 1ps
// Touch swipe detector top level: threshold register, gesture step, output skid.
// Depends on tsd_pkg and tsd_step.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in  (t_tsd_in)
//  out     | output    | o_out_valid / i_out_stall | o_out (t_tsd_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (swipe_threshold)
//
// One transaction per cycle sustained while o_in_stall is low; an accepted result
// is registered after the single-pass gesture logic before it reaches o_out.
// A second register (skid) takes the result when the output is stalled, so
// o_in_stall comes straight from a flop and rises only once both are full.
// Synchronous active-low reset clears tracking state and both valids, and
// loads the threshold with 60. The cfg port is always ready.
module touch_swipe_detector_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input samples
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tsd_pkg::t_tsd_in            i_in,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tsd_pkg::t_tsd_out           o_out,
    // threshold register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsd_pkg::COORD_W-1:0] i_cfg_data
);
    import tsd_pkg::*;

    logic [COORD_W-1:0] r_swipe_threshold;

    logic     w_in_fire;
    logic     w_out_take;
    t_tsd_out w_result;

    t_tsd_out r_out,       n_out;
    logic     r_out_valid, n_out_valid;
    t_tsd_out r_skid,      n_skid;
    logic     r_skid_valid, n_skid_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe_threshold <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_swipe_threshold <= i_cfg_data;
        end
    end

    // stall only when the skid stage holds a result
    assign o_in_stall = r_skid_valid;
    assign w_in_fire  = i_in_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_out_stall;

    tsd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_in_fire),
        .i_item      (i_in),
        .i_threshold (r_swipe_threshold),
        .o_result    (w_result)
    );

    // Output register plus skid. Skid is emptied into the output first;
    // a new result goes to the skid only when the output is held.
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_in_fire) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_in_fire) begin
            n_skid       = w_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // skid never fills ahead of the output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    // a held output with a held skid keeps both
    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid result lost under stall");

    a_start_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.touch_start) |-> (o_out.pressed && o_out.activity))
        else $error("touch_start without a press");

    a_swipe_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.swipe != SWIPE_NONE) |->
            (!o_out.activity && !o_out.pressed &&
             (o_out.swipe == SWIPE_LEFT || o_out.swipe == SWIPE_RIGHT)))
        else $error("swipe reported on a touched sample or bad code");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for touch_swipe_detector_unit: directed and random
// touch gestures under random idling, checked against an in-bench gesture predictor.
// Depends on tsd_pkg and the touch_swipe_detector_unit RTL.
module tb;
    import tsd_pkg::*;

    localparam int SEG_ITEMS   = 200;   // random samples per threshold setting
    localparam int NUM_SEGS    = 8;
    localparam int HOLD_CYCLES = 200;   // long output hold-off to back up the block
    localparam int DRAIN_WAIT  = 4;     // extra wait once both queues are empty
    localparam int COORD_MAX   = PANEL_SIZE - 1;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; all inputs start at known values
    // ------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_tsd_in            i_in        = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_tsd_out           o_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COORD_W-1:0] i_cfg_data  = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    touch_swipe_detector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_tsd_in  sample_q[$];          // samples waiting to be offered, front is on the bus
    t_tsd_out gesture_exp_q[$];     // predicted results, oldest first
    int       samples_queued = 0;
    int       mismatches     = 0;

    // idle percentages, set by the stimulus process per phase
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    // long hold-off request: a bump here starts one hold in the receiver
    int       hold_req    = 0;

    // Predictor copy of the block state
    logic               trk_active  = 1'b0;
    logic               trk_swallow = 1'b0;
    logic [COORD_W-1:0] start_x = '0, start_y = '0, last_x = '0, last_y = '0;
    logic [COORD_W-1:0] thr_mirror = THRESH_RESET;

    // ------------------------------------------------------------------
    // Gesture predictor: one sample in, one result out, state updated.
    // ------------------------------------------------------------------
    function automatic t_tsd_out gesture_next(input t_tsd_in s);
        t_tsd_out           r;
        logic [COORD_W-1:0] adx, ady;
        r       = '0;
        r.swipe = SWIPE_NONE;
        if (s.touched) begin
            r.activity = 1'b1;
            // dimmed screen swallows the touch until the finger lifts
            if (s.dimmed)
                trk_swallow = 1'b1;
            if (trk_swallow) begin
                // any press in flight is dropped, no swipe check later
                trk_active = 1'b0;
            end else begin
                r.pressed = 1'b1;
                // 270 degree rotation; raw x past the panel edge pins y at 0
                r.point_x = s.raw_y;
                r.point_y = (s.raw_x > COORD_MAX) ? '0 : COORD_W'(COORD_MAX) - s.raw_x;
                if (!trk_active) begin
                    trk_active    = 1'b1;
                    start_x       = r.point_x;
                    start_y       = r.point_y;
                    r.touch_start = 1'b1;
                end
                last_x = r.point_x;
                last_y = r.point_y;
            end
        end else begin
            trk_swallow = 1'b0;
            // release: only a live press can turn into a swipe
            if (trk_active) begin
                trk_active = 1'b0;
                adx = (last_x >= start_x) ? last_x - start_x : start_x - last_x;
                ady = (last_y >= start_y) ? last_y - start_y : start_y - last_y;
                if (adx > thr_mirror && adx > ady)
                    r.swipe = (last_x < start_x) ? SWIPE_LEFT : SWIPE_RIGHT;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: holds a stalled transaction, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_in        <= '0;
            trk_active  = 1'b0;
            trk_swallow = 1'b0;
            start_x     = '0;
            start_y     = '0;
            last_x      = '0;
            last_y      = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                gesture_exp_q.push_back(gesture_next(i_in));
                void'(sample_q.pop_front());
            end
            // a stalled transaction stays on the bus untouched
            if (!(i_in_valid && o_in_stall)) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in       <= sample_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus a counted long hold-off on request
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tsd_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gesture_exp_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none got %h",
                         $time, o_out);
                mismatches++;
            end else begin
                want = gesture_exp_q.pop_front();
                check_field("pressed",     want.pressed,     o_out.pressed);
                check_field("point_x",     want.point_x,     o_out.point_x);
                check_field("point_y",     want.point_y,     o_out.point_y);
                check_field("touch_start", want.touch_start, o_out.touch_start);
                check_field("activity",    want.activity,    o_out.activity);
                check_field("swipe",       want.swipe,       o_out.swipe);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(input bit touched, input bit dimmed, input int rx, input int ry);
        t_tsd_in s;
        s.touched = touched;
        s.dimmed  = dimmed;
        s.raw_x   = COORD_W'(rx);
        s.raw_y   = COORD_W'(ry);
        sample_q.push_back(s);
        samples_queued++;
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // One press-move-release sequence. Horizontal travel (raw y) is wide so
    // swipes, near misses and diagonal moves all show up; vertical stays smaller.
    task automatic push_gesture();
        int sx, sy, ex, ey, n, k, px, py;
        bit dim_first;
        sx        = $urandom_range(COORD_MAX);
        sy        = $urandom_range(COORD_MAX);
        ex        = clamp_coord(sx + int'($urandom_range(160)) - 80);
        ey        = clamp_coord(sy + int'($urandom_range(600)) - 300);
        n         = $urandom_range(1, 6);
        dim_first = ($urandom_range(9) == 0);
        for (k = 0; k < n; k++) begin
            px = (n == 1) ? ex : sx + (ex - sx) * k / (n - 1);
            py = (n == 1) ? ey : sy + (ey - sy) * k / (n - 1);
            // now and then a point past the panel edge
            if ($urandom_range(15) == 0)
                px = $urandom_range(511, PANEL_SIZE);
            if ($urandom_range(31) == 0)
                py = $urandom_range(511, PANEL_SIZE);
            push_sample(1'b1, (k == 0 && dim_first) || ($urandom_range(19) == 0), px, py);
        end
        repeat ($urandom_range(1, 2))
            push_sample(1'b0, 1'($urandom_range(1)), $urandom_range(511), $urandom_range(511));
    endtask

    // wait for every sample to be accepted and every result to come back
    task automatic wait_drain();
        while (sample_q.size() != 0 || gesture_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [COORD_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_mirror = v;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                 seg;
        int                 seg_start;
        logic [COORD_W-1:0] thr_plan [NUM_SEGS];

        thr_plan = '{9'd0, 9'd479, 9'd511, 9'd1, 9'd0, 9'd255, 9'd0, 9'd60};
        thr_plan[4] = COORD_W'($urandom_range(511));
        thr_plan[6] = COORD_W'($urandom_range(511));

        repeat (3) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct <= 19;
        rx_idle_pct <= 57;

        // Directed part, reset threshold of 60
        push_sample(0, 0, 300, 200);            // release with no press: no swipe, point 0
        push_sample(1, 0, 0, 0);                // corner points
        push_sample(1, 0, 479, 479);
        push_sample(1, 0, 511, 511);            // raw x past edge pins y, raw y passes
        push_sample(0, 0, 0, 0);                // wide right travel beats vertical
        push_sample(1, 0, 240, 400);            // leftward swipe
        push_sample(1, 0, 240, 100);
        push_sample(0, 1, 0, 0);                // dimmed has no effect on a release
        push_sample(1, 0, 200, 100);            // travel equal to threshold: none
        push_sample(1, 0, 200, 160);
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 200, 100);            // one past threshold: right
        push_sample(1, 0, 200, 161);
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 100, 100);            // horizontal equal to vertical: none
        push_sample(1, 0, 0, 200);
        push_sample(0, 0, 0, 0);
        push_sample(1, 1, 10, 10);              // touch begins dimmed, stays swallowed
        push_sample(1, 0, 10, 300);
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 50, 0);               // press dropped when dimming hits mid-touch
        push_sample(1, 0, 50, 400);
        push_sample(1, 1, 50, 450);
        push_sample(0, 0, 0, 0);
        push_sample(0, 0, 0, 0);                // second release in a row
        wait_drain();

        // Random part, one threshold setting per segment
        for (seg = 0; seg < NUM_SEGS; seg++) begin
            write_threshold(thr_plan[seg]);
            if (seg < 3) begin
                tx_idle_pct <= 19;
                rx_idle_pct <= 57;
            end else if (seg < 6) begin
                tx_idle_pct <= 57;
                rx_idle_pct <= 19;
            end else begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            seg_start = samples_queued;
            while (samples_queued - seg_start < SEG_ITEMS) begin
                if ($urandom_range(99) < 15)
                    push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                $urandom_range(511), $urandom_range(511));
                else
                    push_gesture();
            end
            // sender runs flat out while the receiver holds off: backs up the skid
            if (seg == 6)
                hold_req <= hold_req + 1;
            wait_drain();
        end

        if (mismatches == 0)
            $display("PASS touch_swipe_detector_unit");
        else
            $display("FAIL touch_swipe_detector_unit");
        $finish;
    end

    // Run limit, far beyond the slowest legal run
    initial begin : run_limit
        #2_000_000;
        $display("FAIL touch_swipe_detector_unit");
        $finish;
    end

endmodule
